[hw/rtl/ttb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tick time base package
// Shared types and constants for the tick time base with period flags.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int unsigned NUM_DIVS = 5;
    localparam int unsigned NUM_SEEN = 4;

    localparam int unsigned DIV_MS    = 0;
    localparam int unsigned DIV_F60   = 1;
    localparam int unsigned DIV_F50   = 2;
    localparam int unsigned DIV_FORTY = 3;
    localparam int unsigned DIV_FINE  = 4;

    localparam int unsigned SEEN_MS    = 0;
    localparam int unsigned SEEN_FRAME = 1;
    localparam int unsigned SEEN_FORTY = 2;
    localparam int unsigned SEEN_FINE  = 3;

    localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd8000;
    localparam logic [15:0] DIV_ONE_MS_RESET       = 16'd8;
    localparam logic [15:0] DIV_FRAME_60HZ_RESET   = 16'd112;
    localparam logic [15:0] DIV_FRAME_50HZ_RESET   = 16'd128;
    localparam logic [15:0] DIV_FORTY_MS_RESET     = 16'd320;
    localparam logic [15:0] DIV_FINE_RESET         = 16'd9;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_POLL = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        CFG_TICKS_PER_SECOND = 3'd0,
        CFG_DIV_ONE_MS       = 3'd1,
        CFG_DIV_FRAME_60HZ   = 3'd2,
        CFG_DIV_FRAME_50HZ   = 3'd3,
        CFG_DIV_FORTY_MS     = 3'd4,
        CFG_DIV_FINE         = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic command;
        logic freq_60hz;
    } in_t;

    typedef struct packed {
        logic        fine_flag;
        logic        ms_flag;
        logic        frame_flag;
        logic        forty_ms_flag;
        logic        hour_changed;
        logic [11:0] seconds_now;
        logic [14:0] hours_now;
    } out_t;

endpackage
`default_nettype wire

[hw/rtl/tick_timebase_with_period_flags.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tick time base with period flags
// Cascaded tick, second and hour counters with running dividers and flags.
// ----------------------------------------------------------------------------
// Each input transaction is either a tick, which advances the tick count, the
// running dividers and the second and hour counters and flags fine quotient
// changes, or a poll, which reports which period quotients and the hour count
// changed since the last poll. One transaction is accepted every clock cycle
// unless stalled; its result appears in the output register on the next cycle.
// The rate is set by the single registered pass from the state registers
// through the counter update into the result register. Configuration writes
// are taken on every cycle and should be made only while the block is idle.
module tick_timebase_with_period_flags #(
    parameter int unsigned SECONDS_PER_HOUR = 3600,
    parameter int unsigned HOUR_WRAP        = 32000
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  ttb_pkg::in_t        s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output ttb_pkg::out_t       m_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [2:0]          cfg_index,
    input  wire  [15:0]         cfg_data
);

    logic [15:0] tps_reg;
    logic [15:0] div_reg [ttb_pkg::NUM_DIVS];

    logic [15:0] tick_reg,   tick_next;
    logic [11:0] sec_reg,    sec_next;
    logic [14:0] hour_reg,   hour_next;
    logic [14:0] hour_seen_reg, hour_seen_next;
    logic [15:0] rem_reg  [ttb_pkg::NUM_DIVS];
    logic [15:0] rem_next [ttb_pkg::NUM_DIVS];
    logic [15:0] quo_reg  [ttb_pkg::NUM_DIVS];
    logic [15:0] quo_next [ttb_pkg::NUM_DIVS];
    logic [15:0] seen_reg  [ttb_pkg::NUM_SEEN];
    logic [15:0] seen_next [ttb_pkg::NUM_SEEN];

    logic          m_valid_reg;
    ttb_pkg::out_t m_data_reg, m_data_next;

    logic        accept;
    logic [16:0] tick_inc;
    logic [12:0] sec_inc;
    logic [15:0] hour_inc;
    logic [16:0] rem_inc [ttb_pkg::NUM_DIVS];
    logic [15:0] frame_quo;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        tick_next      = tick_reg;
        sec_next       = sec_reg;
        hour_next      = hour_reg;
        hour_seen_next = hour_seen_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        seen_next      = seen_reg;
        m_data_next    = '0;

        tick_inc  = {1'b0, tick_reg} + 17'd1;
        sec_inc   = {1'b0, sec_reg} + 13'd1;
        hour_inc  = {1'b0, hour_reg} + 16'd1;
        frame_quo = s_data.freq_60hz ? quo_reg[ttb_pkg::DIV_F60]
                                     : quo_reg[ttb_pkg::DIV_F50];
        for (int k = 0; k < ttb_pkg::NUM_DIVS; k++) begin
            rem_inc[k] = {1'b0, rem_reg[k]} + 17'd1;
        end

        if (s_data.command == ttb_pkg::CMD_TICK) begin
            if (tick_inc >= {1'b0, tps_reg}) begin
                tick_next = '0;
                for (int k = 0; k < ttb_pkg::NUM_DIVS; k++) begin
                    rem_next[k] = '0;
                    quo_next[k] = '0;
                end
                if (sec_inc >= 13'(SECONDS_PER_HOUR)) begin
                    sec_next = '0;
                    if (hour_inc >= 16'(HOUR_WRAP)) begin
                        hour_next = '0;
                    end else begin
                        hour_next = hour_inc[14:0];
                    end
                end else begin
                    sec_next = sec_inc[11:0];
                end
            end else begin
                tick_next = tick_inc[15:0];
                for (int k = 0; k < ttb_pkg::NUM_DIVS; k++) begin
                    if (rem_inc[k] >= {1'b0, div_reg[k]}) begin
                        rem_next[k] = '0;
                        quo_next[k] = quo_reg[k] + 16'd1;
                    end else begin
                        rem_next[k] = rem_inc[k][15:0];
                    end
                end
            end
            if (quo_next[ttb_pkg::DIV_FINE] != seen_reg[ttb_pkg::SEEN_FINE]) begin
                seen_next[ttb_pkg::SEEN_FINE] = quo_next[ttb_pkg::DIV_FINE];
                m_data_next.fine_flag         = 1'b1;
            end
        end else begin
            if (quo_reg[ttb_pkg::DIV_MS] != seen_reg[ttb_pkg::SEEN_MS]) begin
                seen_next[ttb_pkg::SEEN_MS] = quo_reg[ttb_pkg::DIV_MS];
                m_data_next.ms_flag         = 1'b1;
            end
            if (frame_quo != seen_reg[ttb_pkg::SEEN_FRAME]) begin
                seen_next[ttb_pkg::SEEN_FRAME] = frame_quo;
                m_data_next.frame_flag         = 1'b1;
            end
            if (quo_reg[ttb_pkg::DIV_FORTY] != seen_reg[ttb_pkg::SEEN_FORTY]) begin
                seen_next[ttb_pkg::SEEN_FORTY] = quo_reg[ttb_pkg::DIV_FORTY];
                m_data_next.forty_ms_flag      = 1'b1;
            end
            if (hour_reg != hour_seen_reg) begin
                hour_seen_next           = hour_reg;
                m_data_next.hour_changed = 1'b1;
            end
        end

        m_data_next.seconds_now = sec_next;
        m_data_next.hours_now   = hour_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg                     <= ttb_pkg::TICKS_PER_SECOND_RESET;
            div_reg[ttb_pkg::DIV_MS]    <= ttb_pkg::DIV_ONE_MS_RESET;
            div_reg[ttb_pkg::DIV_F60]   <= ttb_pkg::DIV_FRAME_60HZ_RESET;
            div_reg[ttb_pkg::DIV_F50]   <= ttb_pkg::DIV_FRAME_50HZ_RESET;
            div_reg[ttb_pkg::DIV_FORTY] <= ttb_pkg::DIV_FORTY_MS_RESET;
            div_reg[ttb_pkg::DIV_FINE]  <= ttb_pkg::DIV_FINE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ttb_pkg::CFG_TICKS_PER_SECOND: tps_reg                     <= cfg_data;
                ttb_pkg::CFG_DIV_ONE_MS:       div_reg[ttb_pkg::DIV_MS]    <= cfg_data;
                ttb_pkg::CFG_DIV_FRAME_60HZ:   div_reg[ttb_pkg::DIV_F60]   <= cfg_data;
                ttb_pkg::CFG_DIV_FRAME_50HZ:   div_reg[ttb_pkg::DIV_F50]   <= cfg_data;
                ttb_pkg::CFG_DIV_FORTY_MS:     div_reg[ttb_pkg::DIV_FORTY] <= cfg_data;
                ttb_pkg::CFG_DIV_FINE:         div_reg[ttb_pkg::DIV_FINE]  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            sec_reg       <= '0;
            hour_reg      <= '0;
            hour_seen_reg <= '0;
            for (int k = 0; k < ttb_pkg::NUM_DIVS; k++) begin
                rem_reg[k] <= '0;
                quo_reg[k] <= '0;
            end
            for (int k = 0; k < ttb_pkg::NUM_SEEN; k++) begin
                seen_reg[k] <= '0;
            end
        end else if (accept) begin
            tick_reg      <= tick_next;
            sec_reg       <= sec_next;
            hour_reg      <= hour_next;
            hour_seen_reg <= hour_seen_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ttb_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tick time base checker
// Port-level assertions for the tick time base, attached by bind.
// ----------------------------------------------------------------------------
module ttb_checker #(
    parameter int unsigned SECONDS_PER_HOUR = 3600,
    parameter int unsigned HOUR_WRAP        = 32000
) (
    input wire           aclk,
    input wire           aresetn,
    input wire           s_valid,
    input wire           s_ready,
    input wire           m_valid,
    input wire           m_ready,
    input ttb_pkg::out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result transaction changed while stalled.");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input not ready while the output register is empty.");

    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("Result transaction appeared without an accepted input.");

    a_flag_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.fine_flag && (m_data.ms_flag || m_data.frame_flag
                      || m_data.forty_ms_flag || m_data.hour_changed)))
        else $error("Tick and poll flags set in the same result.");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.seconds_now < 12'(SECONDS_PER_HOUR))
                    && (m_data.hours_now < 15'(HOUR_WRAP)))
        else $error("Seconds or hours out of range.");

endmodule

bind tick_timebase_with_period_flags ttb_checker #(
    .SECONDS_PER_HOUR(SECONDS_PER_HOUR),
    .HOUR_WRAP(HOUR_WRAP)
) u_ttb_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick time base testbench
// Drives tick and poll transactions with random gaps and output stalls,
// predicts every readout from an independent model of the counters and the
// running dividers, and checks the readouts in order. Configuration is
// rewritten between phases, covering zero and maximum divisors, a zero
// tick period, shrinking divisors and ignored register indexes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned SECONDS_PER_HOUR = 3600;
    localparam int unsigned HOUR_WRAP        = 32000;
    localparam int          CYCLE_LIMIT      = 1000000;
    localparam int          DRAIN_CYCLES     = 4;

    localparam logic [2:0] CFG_SPARE_LOW  = 3'd6;
    localparam logic [2:0] CFG_SPARE_HIGH = 3'd7;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    ttb_pkg::in_t  s_data    = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    ttb_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [15:0]   cfg_data  = '0;

    ttb_pkg::in_t  pending_commands[$];
    ttb_pkg::out_t predicted_readouts[$];

    logic [15:0] timebase_cfg [6];
    logic [15:0] tick_count   = '0;
    logic [11:0] second_count = '0;
    logic [14:0] hour_count   = '0;
    logic [14:0] hour_seen    = '0;
    logic [15:0] div_rem  [ttb_pkg::NUM_DIVS] = '{default: '0};
    logic [15:0] div_quo  [ttb_pkg::NUM_DIVS] = '{default: '0};
    logic [15:0] quo_seen [ttb_pkg::NUM_SEEN] = '{default: '0};

    int error_count = 0;
    int cycle_count = 0;
    int send_gap    = 0;
    int send_burst  = 0;
    int recv_stall  = 0;
    int recv_burst  = 0;

    tick_timebase_with_period_flags #(
        .SECONDS_PER_HOUR(SECONDS_PER_HOUR),
        .HOUR_WRAP(HOUR_WRAP)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(8, 40);
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic logic record_change(int unsigned slot, logic [15:0] quotient);
        if (quotient != quo_seen[slot]) begin
            quo_seen[slot] = quotient;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic ttb_pkg::out_t advance_timebase(ttb_pkg::in_t item);
        ttb_pkg::out_t res;
        logic [16:0]   nxt;
        logic [15:0]   divisor;
        logic [15:0]   frame_q;
        int            k;
        res = '0;
        if (item.command == ttb_pkg::CMD_TICK) begin
            nxt = {1'b0, tick_count} + 17'd1;
            if (nxt >= {1'b0, timebase_cfg[ttb_pkg::CFG_TICKS_PER_SECOND]}) begin
                tick_count = '0;
                for (k = 0; k < ttb_pkg::NUM_DIVS; k++) begin
                    div_rem[k] = '0;
                    div_quo[k] = '0;
                end
                if (second_count + 1 >= SECONDS_PER_HOUR) begin
                    second_count = '0;
                    if (hour_count + 1 >= HOUR_WRAP) begin
                        hour_count = '0;
                    end else begin
                        hour_count = hour_count + 15'd1;
                    end
                end else begin
                    second_count = second_count + 12'd1;
                end
            end else begin
                tick_count = nxt[15:0];
                for (k = 0; k < ttb_pkg::NUM_DIVS; k++) begin
                    case (k)
                        ttb_pkg::DIV_MS:    divisor = timebase_cfg[ttb_pkg::CFG_DIV_ONE_MS];
                        ttb_pkg::DIV_F60:   divisor = timebase_cfg[ttb_pkg::CFG_DIV_FRAME_60HZ];
                        ttb_pkg::DIV_F50:   divisor = timebase_cfg[ttb_pkg::CFG_DIV_FRAME_50HZ];
                        ttb_pkg::DIV_FORTY: divisor = timebase_cfg[ttb_pkg::CFG_DIV_FORTY_MS];
                        default:            divisor = timebase_cfg[ttb_pkg::CFG_DIV_FINE];
                    endcase
                    if ({1'b0, div_rem[k]} + 17'd1 >= {1'b0, divisor}) begin
                        div_rem[k] = '0;
                        div_quo[k] = div_quo[k] + 16'd1;
                    end else begin
                        div_rem[k] = div_rem[k] + 16'd1;
                    end
                end
            end
            res.fine_flag = record_change(ttb_pkg::SEEN_FINE, div_quo[ttb_pkg::DIV_FINE]);
        end else begin
            frame_q = item.freq_60hz ? div_quo[ttb_pkg::DIV_F60] : div_quo[ttb_pkg::DIV_F50];
            res.ms_flag       = record_change(ttb_pkg::SEEN_MS, div_quo[ttb_pkg::DIV_MS]);
            res.frame_flag    = record_change(ttb_pkg::SEEN_FRAME, frame_q);
            res.forty_ms_flag = record_change(ttb_pkg::SEEN_FORTY,
                                              div_quo[ttb_pkg::DIV_FORTY]);
            if (hour_count != hour_seen) begin
                hour_seen = hour_count;
                res.hour_changed = 1'b1;
            end
        end
        res.seconds_now = second_count;
        res.hours_now   = hour_count;
        return res;
    endfunction

    function automatic void compare_field(string field, logic [14:0] want, logic [14:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    task automatic check_readout(ttb_pkg::out_t got);
        ttb_pkg::out_t want;
        if (predicted_readouts.size() == 0) begin
            $error("result transaction with no prediction pending");
            error_count++;
        end else begin
            want = predicted_readouts.pop_front();
            compare_field("fine_flag", 15'(want.fine_flag), 15'(got.fine_flag));
            compare_field("ms_flag", 15'(want.ms_flag), 15'(got.ms_flag));
            compare_field("frame_flag", 15'(want.frame_flag), 15'(got.frame_flag));
            compare_field("forty_ms_flag", 15'(want.forty_ms_flag), 15'(got.forty_ms_flag));
            compare_field("hour_changed", 15'(want.hour_changed), 15'(got.hour_changed));
            compare_field("seconds_now", 15'(want.seconds_now), 15'(got.seconds_now));
            compare_field("hours_now", want.hours_now, got.hours_now);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_readouts.push_back(advance_timebase(s_data));
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_commands.size() != 0) begin
                    s_data   <= pending_commands.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= draw_wait(send_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else if (m_valid && m_ready) begin
            check_readout(m_data);
            n = draw_wait(recv_burst);
            recv_stall <= n;
            m_ready    <= (n == 0);
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            m_ready    <= (recv_stall == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= ttb_pkg::CFG_DIV_FINE) begin
            timebase_cfg[idx] = value;
        end
    endtask

    task automatic set_timebase(logic [15:0] tps, logic [15:0] ms, logic [15:0] f60,
                                logic [15:0] f50, logic [15:0] forty, logic [15:0] fine);
        write_reg(ttb_pkg::CFG_TICKS_PER_SECOND, tps);
        write_reg(ttb_pkg::CFG_DIV_ONE_MS, ms);
        write_reg(ttb_pkg::CFG_DIV_FRAME_60HZ, f60);
        write_reg(ttb_pkg::CFG_DIV_FRAME_50HZ, f50);
        write_reg(ttb_pkg::CFG_DIV_FORTY_MS, forty);
        write_reg(ttb_pkg::CFG_DIV_FINE, fine);
    endtask

    task automatic queue_command(ttb_pkg::command_t cmd, logic sixty);
        ttb_pkg::in_t item;
        item.command   = cmd;
        item.freq_60hz = sixty;
        pending_commands.push_back(item);
    endtask

    task automatic queue_random(int count, int poll_pct);
        int i;
        for (i = 0; i < count; i++) begin
            queue_command(($urandom_range(0, 99) < poll_pct) ? ttb_pkg::CMD_POLL
                                                             : ttb_pkg::CMD_TICK,
                          logic'($urandom_range(0, 1)));
        end
    endtask

    // Settle on the falling edge so that transactions launched at the last
    // rising edge are already visible.
    task automatic drain_block();
        do @(negedge aclk);
        while (pending_commands.size() != 0 || s_valid || predicted_readouts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int i;
        timebase_cfg[ttb_pkg::CFG_TICKS_PER_SECOND] = ttb_pkg::TICKS_PER_SECOND_RESET;
        timebase_cfg[ttb_pkg::CFG_DIV_ONE_MS]       = ttb_pkg::DIV_ONE_MS_RESET;
        timebase_cfg[ttb_pkg::CFG_DIV_FRAME_60HZ]   = ttb_pkg::DIV_FRAME_60HZ_RESET;
        timebase_cfg[ttb_pkg::CFG_DIV_FRAME_50HZ]   = ttb_pkg::DIV_FRAME_50HZ_RESET;
        timebase_cfg[ttb_pkg::CFG_DIV_FORTY_MS]     = ttb_pkg::DIV_FORTY_MS_RESET;
        timebase_cfg[ttb_pkg::CFG_DIV_FINE]         = ttb_pkg::DIV_FINE_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        queue_command(ttb_pkg::CMD_POLL, 1'b1);
        queue_command(ttb_pkg::CMD_POLL, 1'b0);
        for (i = 0; i < 10; i++) begin
            queue_command(ttb_pkg::CMD_TICK, i[0]);
        end
        queue_command(ttb_pkg::CMD_POLL, 1'b1);
        queue_command(ttb_pkg::CMD_POLL, 1'b1);
        queue_random(60, 25);
        drain_block();

        set_timebase(16'd20, 16'd1, 16'd2, 16'd3, 16'd5, 16'd4);
        write_reg(CFG_SPARE_LOW, 16'hFFFF);
        write_reg(CFG_SPARE_HIGH, 16'h0001);
        for (i = 0; i < 6; i++) begin
            queue_command(ttb_pkg::CMD_TICK, i[1]);
        end
        queue_command(ttb_pkg::CMD_POLL, 1'b1);
        queue_command(ttb_pkg::CMD_POLL, 1'b0);
        queue_command(ttb_pkg::CMD_POLL, 1'b1);
        queue_random(100, 25);
        drain_block();

        // Two divisors shrink, one of them to zero; the 60 Hz frame divisor rises to its maximum.
        write_reg(ttb_pkg::CFG_DIV_FINE, 16'd1);
        write_reg(ttb_pkg::CFG_DIV_ONE_MS, 16'd0);
        write_reg(ttb_pkg::CFG_DIV_FRAME_60HZ, 16'hFFFF);
        queue_random(60, 25);
        drain_block();

        set_timebase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_random(60, 30);
        drain_block();

        set_timebase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(60, 25);
        drain_block();

        // One second per tick.
        set_timebase(16'd1, 16'd3, 16'd2, 16'd5, 16'd7, 16'd4);
        queue_random(60, 3);
        queue_command(ttb_pkg::CMD_POLL, 1'b0);
        queue_command(ttb_pkg::CMD_POLL, 1'b1);
        drain_block();

        for (i = 0; i < 3; i++) begin
            set_timebase(16'($urandom_range(1, 64)), 16'($urandom_range(0, 12)),
                         16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                         16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
            queue_random(60, 25);
            drain_block();
        end

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[tick_timebase_with_period_flags.f]
hw/rtl/ttb_pkg.sv
hw/rtl/tick_timebase_with_period_flags.sv
hw/rtl/ttb_checker.sv
tb/tb_top.sv
